### src/hht_pkg.sv
// shared constants and codes of the hopscotch hash table
package hht_pkg;

  localparam int TABLE_SLOTS  = 64;
  localparam int NEIGHBORHOOD = 4;

  localparam int IDX_W   = $clog2(TABLE_SLOTS);
  localparam int K_W     = $clog2(NEIGHBORHOOD + 1);
  localparam int KEY_W   = 31;
  localparam int CMD_W   = 2;
  localparam int STAT_W  = 3;
  localparam int LOC_W   = 6;
  localparam int COUNT_W = 7;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

  localparam logic [STAT_W-1:0] ST_INSERTED = 3'd0;
  localparam logic [STAT_W-1:0] ST_FOUND    = 3'd1;
  localparam logic [STAT_W-1:0] ST_MISSING  = 3'd2;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd3;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd4;

endpackage

### src/hht_ram.sv
// generic single-port-write, single-port-read ram with registered read
module hht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### src/hopscotch_hash_table.sv
// top level of the hopscotch hash table: sequencer, valid bits and key ram
//
//   channel  signals                      payload
//   in       in_valid / in_stall          command, key
//   out      out_valid / out_stall        status, location
//
// one request at a time; lookup reads and then compares each neighborhood slot in turn (S_LOOK_RD, S_LOOK_CMP)
// insert probes slot by slot for a free one, checks it (S_CHECK) and moves entries into the hole (S_SCAN, S_MOVE)
// clear, unused commands and lookups of an empty table go straight to the result; the key ram read port sets the pace
// reset empties the table at once through the valid flops, no clearing pass
// a stalled result holds the sequencer in its last step until it is taken
module hopscotch_hash_table (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [hht_pkg::CMD_W-1:0]   command,
  input  logic [hht_pkg::KEY_W-1:0]   key,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [hht_pkg::STAT_W-1:0]  status,
  output logic [hht_pkg::LOC_W-1:0]   location
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_PROBE    = 3'd1;
  localparam logic [2:0] S_CHECK    = 3'd2;
  localparam logic [2:0] S_SCAN     = 3'd3;
  localparam logic [2:0] S_MOVE     = 3'd4;
  localparam logic [2:0] S_LOOK_RD  = 3'd5;
  localparam logic [2:0] S_LOOK_CMP = 3'd6;
  localparam logic [2:0] S_DONE     = 3'd7;

  logic [2:0]                     state;
  logic [hht_pkg::KEY_W-1:0]      key_r;
  logic [hht_pkg::IDX_W-1:0]      home;
  logic [hht_pkg::IDX_W-1:0]      cur;
  logic [hht_pkg::IDX_W-1:0]      cnt;
  logic [hht_pkg::K_W-1:0]        k;
  logic [hht_pkg::TABLE_SLOTS-1:0] slot_valid;
  logic [hht_pkg::COUNT_W-1:0]    entry_count;
  logic [hht_pkg::STAT_W-1:0]     res_status;
  logic [hht_pkg::IDX_W-1:0]      res_slot;

  logic                           ram_we;
  logic                           ram_re;
  logic [hht_pkg::IDX_W-1:0]      ram_raddr;
  logic [hht_pkg::KEY_W-1:0]      ram_wdata;
  logic [hht_pkg::KEY_W-1:0]      rd_data;

  logic [hht_pkg::IDX_W-1:0]      scan_j;
  logic [hht_pkg::IDX_W-1:0]      home_dist;
  logic [hht_pkg::IDX_W-1:0]      cand_dist;
  logic                           home_near;
  logic                           cand_fits;
  logic                           out_free;

  assign in_stall  = (state != S_IDLE);
  assign out_free  = !out_valid || !out_stall;
  assign scan_j    = cur - hht_pkg::IDX_W'(k);
  assign home_dist = cur - home;
  assign cand_dist = cur - rd_data[hht_pkg::IDX_W-1:0];
  assign home_near = 32'(home_dist) < 32'(hht_pkg::NEIGHBORHOOD);
  assign cand_fits = 32'(cand_dist) < 32'(hht_pkg::NEIGHBORHOOD);

  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = key_r;
    ram_re    = 1'b0;
    ram_raddr = cur;
    case (state)
      S_CHECK: begin
        ram_we = home_near;
      end
      S_SCAN: begin
        ram_re    = 1'b1;
        ram_raddr = scan_j;
      end
      S_MOVE: begin
        ram_we    = cand_fits;
        ram_wdata = rd_data;
      end
      S_LOOK_RD: begin
        ram_re = 1'b1;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  hht_ram #(
    .WIDTH (hht_pkg::KEY_W),
    .DEPTH (hht_pkg::TABLE_SLOTS)
  ) u_key_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (cur),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      slot_valid  <= '0;
      entry_count <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            key_r    <= key;
            home     <= key[hht_pkg::IDX_W-1:0];
            cur      <= key[hht_pkg::IDX_W-1:0];
            cnt      <= '0;
            k        <= '0;
            res_slot <= '0;
            case (command)
              hht_pkg::CMD_INSERT: begin
                state <= S_PROBE;
              end
              hht_pkg::CMD_LOOKUP: begin
                if (entry_count == '0) begin
                  res_status <= hht_pkg::ST_EMPTY;
                  state      <= S_DONE;
                end else begin
                  state <= S_LOOK_RD;
                end
              end
              hht_pkg::CMD_CLEAR: begin
                slot_valid  <= '0;
                entry_count <= '0;
                res_status  <= hht_pkg::ST_EMPTY;
                state       <= S_DONE;
              end
              default: begin
                res_status <= hht_pkg::ST_MISSING;
                state      <= S_DONE;
              end
            endcase
          end
        end
        S_PROBE: begin
          if (!slot_valid[cur]) begin
            state <= S_CHECK;
          end else if (cnt == hht_pkg::IDX_W'(hht_pkg::TABLE_SLOTS - 1)) begin
            res_status <= hht_pkg::ST_FULL;
            state      <= S_DONE;
          end else begin
            cur <= cur + hht_pkg::IDX_W'(1);
            cnt <= cnt + hht_pkg::IDX_W'(1);
          end
        end
        S_CHECK: begin
          if (home_near) begin
            slot_valid[cur] <= 1'b1;
            if (entry_count != hht_pkg::COUNT_MAX) begin
              entry_count <= entry_count + hht_pkg::COUNT_W'(1);
            end
            res_status <= hht_pkg::ST_INSERTED;
            res_slot   <= cur;
            state      <= S_DONE;
          end else begin
            k     <= hht_pkg::K_W'(hht_pkg::NEIGHBORHOOD - 1);
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (k == '0) begin
            res_status <= hht_pkg::ST_FULL;
            state      <= S_DONE;
          end else if (slot_valid[scan_j]) begin
            state <= S_MOVE;
          end else begin
            k <= k - hht_pkg::K_W'(1);
          end
        end
        S_MOVE: begin
          if (cand_fits) begin
            slot_valid <= (slot_valid | (hht_pkg::TABLE_SLOTS'(1) << cur)) &
                          ~(hht_pkg::TABLE_SLOTS'(1) << scan_j);
            cur        <= scan_j;
            state      <= S_CHECK;
          end else begin
            k     <= k - hht_pkg::K_W'(1);
            state <= S_SCAN;
          end
        end
        S_LOOK_RD: begin
          state <= S_LOOK_CMP;
        end
        S_LOOK_CMP: begin
          if (slot_valid[cur] && rd_data == key_r) begin
            res_status <= hht_pkg::ST_FOUND;
            res_slot   <= cur;
            state      <= S_DONE;
          end else if (k == hht_pkg::K_W'(hht_pkg::NEIGHBORHOOD - 1)) begin
            res_status <= hht_pkg::ST_MISSING;
            state      <= S_DONE;
          end else begin
            k     <= k + hht_pkg::K_W'(1);
            cur   <= cur + hht_pkg::IDX_W'(1);
            state <= S_LOOK_RD;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      status   <= res_status;
      location <= hht_pkg::LOC_W'(res_slot);
    end
  end

`ifndef SYNTHESIS
  a_count_matches_valid: assert property (@(posedge clk) disable iff (rst)
    32'(entry_count) == $countones(slot_valid))
    else $error("entry count differs from number of occupied slots");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && in_valid && command == hht_pkg::CMD_CLEAR) |=> slot_valid == '0)
    else $error("clear left occupied slots");

  a_check_slot_empty: assert property (@(posedge clk) disable iff (rst)
    state == S_CHECK |-> !slot_valid[cur])
    else $error("hole slot is occupied");

  a_move_source_valid: assert property (@(posedge clk) disable iff (rst)
    state == S_MOVE |-> slot_valid[scan_j] && $past(state) == S_SCAN)
    else $error("displacement from an empty slot");
`endif

endmodule
